// File: hw/rtl/lrusc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrusc_pkg: shared types for the LRU stage result cache
// Per-cell control bundle, neighbor chain record and sequencer states.
// ----------------------------------------------------------------------------
package lrusc_pkg;

   localparam int KEY_W     = 64;
   localparam int WANT_W    = 6;
   localparam int STAGE_W   = 5;
   localparam int CAP_W     = 5;
   localparam int SMALL_W   = 5;
   localparam int TOTAL_W   = 32;
   localparam int ENTRIES_D = 16;
   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_UPDATE
   } lrusc_state_type;

   // broadcast from the sequencer to every cell
   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic               capture;
      logic               update;
      logic               hit;
      logic [STAGE_W-1:0] need;
   } lrusc_ctl_type;

   // record handed from one cell to the next
   typedef struct packed {
      logic               found;
      logic [STAGE_W-1:0] present;
      logic               taken;
   } lrusc_chain_type;

endpackage
`default_nettype wire

// File: hw/rtl/lru_stage_result_cache_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lru_stage_result_cache_core: fully associative LRU cache of stage bits
// A row of entry cells looks up a position key, reports hit status and newly
// computed stages, refreshes recency and evicts the least recent entries.
//
//   channel   direction  handshake          payload
//   req       in         req_valid/stall    position_key, has_position, want_mask
//   rsp       out        rsp_valid/stall    hit status, masks, counts, totals
//   csr       in         csr_valid/ready    capacity
//
// A request is accepted in the idle state, where the key compare runs along
// the cell row; the update state then applies aging, eviction and insertion.
// Results sit in an output register; a stalled result holds the update
// state until the register frees. Reset clears all entries and totals.
// ----------------------------------------------------------------------------
module lru_stage_result_cache_core import lrusc_pkg::*; #(
   parameter int ENTRIES = ENTRIES_D
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [KEY_W-1:0]   req_position_key,
   input  wire logic               req_has_position,
   input  wire logic [WANT_W-1:0]  req_want_mask,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_consulted,
   output logic                    rsp_any_hit,
   output logic                    rsp_full_hit,
   output logic [STAGE_W-1:0]      rsp_computed_mask,
   output logic [SMALL_W-1:0]      rsp_evicted_count,
   output logic [TOTAL_W-1:0]      rsp_request_total,
   output logic [TOTAL_W-1:0]      rsp_any_hit_total,
   output logic [TOTAL_W-1:0]      rsp_full_hit_total,
   output logic [TOTAL_W-1:0]      rsp_miss_total,
   output logic [TOTAL_W-1:0]      rsp_eviction_total,
   output logic [SMALL_W-1:0]      rsp_entry_count,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [CAP_W-1:0]   csr_capacity
);

   localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int LIM_W  = RANK_W + 1;
   localparam int CNT_W  = $clog2(ENTRIES + 1);

   lrusc_state_type state_ff, state_in;

   logic [CAP_W-1:0]   cap_ff;
   logic [CNT_W-1:0]   eff_cap;
   logic [CNT_W-1:0]   held_ff, held_in;
   logic [CNT_W-1:0]   evicted;

   logic [KEY_W-1:0]   key_ff;
   logic [STAGE_W-1:0] need_ff, need_now;
   logic               consulted_ff, consulted_now;
   logic               hit_ff;
   logic [STAGE_W-1:0] present_ff;
   logic [RANK_W-1:0]  hit_rank_ff;

   logic [TOTAL_W-1:0] req_total_ff, any_total_ff, full_total_ff;
   logic [TOTAL_W-1:0] miss_total_ff, evict_total_ff;

   logic               rsp_valid_ff;
   logic               out_free, accept, finish;
   logic               any_now, full_now;
   logic [STAGE_W-1:0] computed_now;

   lrusc_ctl_type      ctl;
   lrusc_chain_type    chain [ENTRIES+1];
   logic [RANK_W-1:0]  rank_chain [ENTRIES+1];
   logic [ENTRIES-1:0] valid_vec, match_vec;

   // handshakes
   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign finish    = (state_ff == ST_UPDATE) && out_free;

   always_comb begin
      need_now[0]   = req_want_mask[0] | req_want_mask[1] | req_want_mask[2] |
                      req_want_mask[3] | req_want_mask[5];
      need_now[1]   = req_want_mask[1] | req_want_mask[2] | req_want_mask[3];
      need_now[2]   = req_want_mask[2] | req_want_mask[3];
      need_now[3]   = req_want_mask[3];
      need_now[4]   = req_want_mask[4];
      consulted_now = req_has_position && (req_want_mask != '0);
   end

   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = CNT_W'(1);
      end else if (int'(cap_ff) > ENTRIES) begin
         eff_cap = CNT_W'(ENTRIES);
      end else begin
         eff_cap = CNT_W'(cap_ff);
      end
   end

   // cell row
   assign ctl.key     = (state_ff == ST_IDLE) ? req_position_key : key_ff;
   assign ctl.capture = accept;
   assign ctl.update  = finish && consulted_ff;
   assign ctl.hit     = hit_ff;
   assign ctl.need    = need_ff;

   assign chain[0]      = '0;
   assign rank_chain[0] = '0;

   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      lrusc_cell #(
         .RANK_W (RANK_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .hit_rank  (hit_rank_ff),
         .limit     (LIM_W'(eff_cap)),
         .chain_in  (chain[g]),
         .rank_in   (rank_chain[g]),
         .chain_out (chain[g+1]),
         .rank_out  (rank_chain[g+1]),
         .valid     (valid_vec[g]),
         .match     (match_vec[g])
      );
   end

   // eviction count and hit status
   always_comb begin
      if (hit_ff) begin
         evicted = (held_ff > eff_cap) ? (held_ff - eff_cap) : '0;
         held_in = held_ff - evicted;
      end else begin
         evicted = (held_ff >= eff_cap) ? (held_ff - eff_cap + 1'b1) : '0;
         held_in = held_ff - evicted + 1'b1;
      end
      any_now      = (need_ff & present_ff) != '0;
      full_now     = (need_ff & ~present_ff) == '0;
      computed_now = need_ff & ~present_ff;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff         <= CAP_RESET;
         held_ff        <= '0;
         consulted_ff   <= 1'b0;
         hit_ff         <= 1'b0;
         req_total_ff   <= '0;
         any_total_ff   <= '0;
         full_total_ff  <= '0;
         miss_total_ff  <= '0;
         evict_total_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            cap_ff <= csr_capacity;
         end
         if (accept) begin
            consulted_ff <= consulted_now;
            hit_ff       <= chain[ENTRIES].found;
         end
         if (finish && consulted_ff) begin
            held_ff        <= held_in;
            req_total_ff   <= req_total_ff + 1'b1;
            any_total_ff   <= any_total_ff + TOTAL_W'(any_now);
            full_total_ff  <= full_total_ff + TOTAL_W'(full_now);
            miss_total_ff  <= miss_total_ff + TOTAL_W'(!any_now);
            evict_total_ff <= evict_total_ff + TOTAL_W'(evicted);
         end
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         key_ff      <= req_position_key;
         need_ff     <= need_now;
         present_ff  <= chain[ENTRIES].present;
         hit_rank_ff <= rank_chain[ENTRIES];
      end
      if (finish) begin
         if (consulted_ff) begin
            rsp_consulted       <= 1'b1;
            rsp_any_hit         <= any_now;
            rsp_full_hit        <= full_now;
            rsp_computed_mask   <= computed_now;
            rsp_evicted_count   <= SMALL_W'(evicted);
            rsp_request_total   <= req_total_ff + 1'b1;
            rsp_any_hit_total   <= any_total_ff + TOTAL_W'(any_now);
            rsp_full_hit_total  <= full_total_ff + TOTAL_W'(full_now);
            rsp_miss_total      <= miss_total_ff + TOTAL_W'(!any_now);
            rsp_eviction_total  <= evict_total_ff + TOTAL_W'(evicted);
            rsp_entry_count     <= SMALL_W'(held_in);
         end else begin
            rsp_consulted       <= 1'b0;
            rsp_any_hit         <= 1'b0;
            rsp_full_hit        <= 1'b0;
            rsp_computed_mask   <= '0;
            rsp_evicted_count   <= '0;
            rsp_request_total   <= req_total_ff;
            rsp_any_hit_total   <= any_total_ff;
            rsp_full_hit_total  <= full_total_ff;
            rsp_miss_total      <= miss_total_ff;
            rsp_eviction_total  <= evict_total_ff;
            rsp_entry_count     <= SMALL_W'(held_ff);
         end
      end
   end

   // checks
   a_held_matches_cells: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == int'(held_ff))
      else $error("held count differs from valid cells");

   a_unique_key: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match_vec))
      else $error("key held by more than one cell");

   a_held_bounded: assert property (@(posedge clock) disable iff (reset)
      $past(ctl.update) |-> (held_ff <= eff_cap || $past(cap_ff) != cap_ff))
      else $error("entries above capacity after update");

   a_update_single_cycle: assert property (@(posedge clock) disable iff (reset)
      finish |=> (state_ff == ST_IDLE && rsp_valid_ff))
      else $error("update did not complete into output register");

endmodule
`default_nettype wire

// File: hw/rtl/lrusc_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrusc_cell: one cache entry
// Holds key, presence bits and recency rank; compares, ages and evicts itself
// and passes lookup and free-slot results to its neighbor.
// ----------------------------------------------------------------------------
module lrusc_cell import lrusc_pkg::*; #(
   parameter int RANK_W = 4
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire lrusc_ctl_type   ctl,
   input  wire logic [RANK_W-1:0] hit_rank,
   input  wire logic [RANK_W:0] limit,
   input  wire lrusc_chain_type chain_in,
   input  wire logic [RANK_W-1:0] rank_in,
   output lrusc_chain_type      chain_out,
   output logic [RANK_W-1:0]    rank_out,
   output logic                 valid,
   output logic                 match
);

   logic [KEY_W-1:0]   key_ff;
   logic               valid_ff;
   logic [STAGE_W-1:0] present_ff;
   logic [RANK_W-1:0]  rank_ff;
   logic               match_ff;
   logic               match_now;
   logic [RANK_W:0]    new_rank;
   logic               evict;
   logic               free_after;
   logic               insert;

   assign match_now = valid_ff && (key_ff == ctl.key);
   assign valid     = valid_ff;
   assign match     = match_now;

   always_comb begin
      if (ctl.hit) begin
         if (match_ff) begin
            new_rank = '0;
         end else if (rank_ff < hit_rank) begin
            new_rank = {1'b0, rank_ff} + 1'b1;
         end else begin
            new_rank = {1'b0, rank_ff};
         end
      end else begin
         new_rank = {1'b0, rank_ff} + 1'b1;
      end
      evict      = valid_ff && (new_rank >= limit);
      free_after = !valid_ff || evict;
      insert     = !ctl.hit && free_after && !chain_in.taken;

      chain_out.found   = chain_in.found || match_now;
      chain_out.present = match_now ? present_ff : chain_in.present;
      chain_out.taken   = chain_in.taken || free_after;
      rank_out          = match_now ? rank_ff : rank_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         present_ff <= '0;
         rank_ff    <= '0;
         match_ff   <= 1'b0;
      end else begin
         if (ctl.capture) begin
            match_ff <= match_now;
         end
         if (ctl.update) begin
            if (insert) begin
               valid_ff   <= 1'b1;
               present_ff <= ctl.need;
               rank_ff    <= '0;
            end else if (evict) begin
               valid_ff   <= 1'b0;
               present_ff <= '0;
               rank_ff    <= '0;
            end else if (valid_ff) begin
               rank_ff <= new_rank[RANK_W-1:0];
               if (match_ff && ctl.hit) begin
                  present_ff <= present_ff | ctl.need;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.update && insert) begin
         key_ff <= ctl.key;
      end
   end

endmodule
`default_nettype wire
